// ===== rtl/bfm_pkg.sv =====
// Package for the buffer frame manager: sizes, command and status codes,
// frame descriptor and result types. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bfm_pkg;

  localparam int NumFrames = 16;
  localparam int FrameW    = $clog2(NumFrames);
  localparam int FileW     = 8;
  localparam int PageW     = 24;
  localparam int PinW      = 8;

  localparam logic [PinW-1:0]   PinMax    = {PinW{1'b1}};
  localparam logic [FrameW-1:0] LastFrame = FrameW'(NumFrames - 1);

  typedef enum logic [2:0] {
    CmdRead    = 3'd0,
    CmdUnpin   = 3'd1,
    CmdAlloc   = 3'd2,
    CmdDispose = 3'd3,
    CmdFlush   = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    StOk        = 3'd0,
    StExceeded  = 3'd1,
    StNotFound  = 3'd2,
    StNotPinned = 3'd3,
    StPinned    = 3'd4
  } status_e;

  // One frame descriptor
  typedef struct packed {
    logic             valid;
    logic [FileW-1:0] file;
    logic [PageW-1:0] page;
    logic [PinW-1:0]  pin;
    logic             ref_bit;
    logic             dirty;
  } entry_t;

  // Write port into the frame table
  typedef struct packed {
    logic              we;
    logic [FrameW-1:0] idx;
    entry_t            entry;
  } tbl_wr_t;

  // One result item
  typedef struct packed {
    status_e           status;
    logic [FrameW-1:0] frame;
    logic              hit;
    logic              need_load;
    logic              writeback;
    logic [FileW-1:0]  wb_file;
    logic [PageW-1:0]  wb_page;
    logic              last;
  } result_t;

  // Result push from the sequencer to the output register
  typedef struct packed {
    logic    load;
    result_t res;
  } emit_t;

endpackage

`default_nettype wire

// ===== rtl/bfm_frame_table.sv =====
// Frame descriptor table: NumFrames entries, one read port, one write port.
// Depends on bfm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bfm_frame_table
  import bfm_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [FrameW-1:0] rd_idx_i,
  output entry_t                 rd_entry_o,
  input  wire tbl_wr_t           wr_i
);

  entry_t tbl_q [NumFrames];

  // Storage, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumFrames; i++) begin
        tbl_q[i] <= '0;
      end
    end else if (wr_i.we) begin
      tbl_q[wr_i.idx] <= wr_i.entry;
    end
  end

  assign rd_entry_o = tbl_q[rd_idx_i];

endmodule

`default_nettype wire

// ===== rtl/bfm_out_reg.sv =====
// Output register for result items, holds while the receiver stalls.
// Depends on bfm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bfm_out_reg
  import bfm_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire emit_t emit_i,
  output logic       free_o,
  output logic       out_valid_o,
  input  wire logic  out_stall_i,
  output result_t    out_res_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  // Free when empty or the held result leaves this cycle
  assign free_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (emit_i.load) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_i.load) begin
      res_q <= emit_i.res;
    end
  end

  assign out_valid_o = valid_q;
  assign out_res_o   = res_q;

endmodule

`default_nettype wire

// ===== rtl/bfm_ctrl.sv =====
// Command sequencer: one frame compare/update per cycle for lookup, clock sweep and
// file flush, a flush holding while a write-back waits. Depends on bfm_pkg; drives bfm_frame_table.
`timescale 1ns / 1ps
`default_nettype none

module bfm_ctrl
  import bfm_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [2:0]        command_i,
  input  wire logic [FileW-1:0]  file_id_i,
  input  wire logic [PageW-1:0]  page_no_i,
  input  wire logic              mark_dirty_i,
  output logic [FrameW-1:0]      rd_idx_o,
  input  wire entry_t            rd_entry_i,
  output tbl_wr_t                wr_o,
  input  wire logic              out_free_i,
  output emit_t                  emit_o
);

  typedef enum logic [5:0] {
    SIdle   = 6'b000001,
    SLookup = 6'b000010,
    SApply  = 6'b000100,
    SSweep  = 6'b001000,
    SFlush  = 6'b010000,
    SEmit   = 6'b100000
  } state_e;

  state_e            state_q, state_d;
  logic [2:0]        cmd_q, cmd_d;
  logic [FileW-1:0]  file_q, file_d;
  logic [PageW-1:0]  page_q, page_d;
  logic              mark_q, mark_d;
  logic [FrameW-1:0] idx_q, idx_d;
  logic              match_q, match_d;
  logic [FrameW-1:0] match_idx_q, match_idx_d;
  logic              avail_q, avail_d;
  logic [FrameW-1:0] hand_q, hand_d;
  result_t           res_q, res_d;

  logic              same_file;
  logic              same_page;
  logic [FrameW-1:0] hand_next;
  logic              is_fetch;
  entry_t            e;

  assign e          = rd_entry_i;
  assign same_file  = e.valid && (e.file == file_q);
  assign same_page  = same_file && (e.page == page_q);
  assign hand_next  = (hand_q == LastFrame) ? '0 : hand_q + 1'b1;
  assign is_fetch   = (cmd_q == CmdRead) || (cmd_q == CmdAlloc);
  assign in_stall_o = (state_q != SIdle);

  // Sequencer
  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    file_d      = file_q;
    page_d      = page_q;
    mark_d      = mark_q;
    idx_d       = idx_q;
    match_d     = match_q;
    match_idx_d = match_idx_q;
    avail_d     = avail_q;
    hand_d      = hand_q;
    res_d       = res_q;
    rd_idx_o    = idx_q;
    wr_o        = '0;
    emit_o      = '0;

    case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          cmd_d   = command_i;
          file_d  = file_id_i;
          page_d  = page_no_i;
          mark_d  = mark_dirty_i;
          idx_d   = '0;
          match_d = 1'b0;
          avail_d = 1'b0;
          res_d   = '0;
          res_d.status = StOk;
          res_d.last   = 1'b1;
          case (command_i)
            CmdRead, CmdUnpin, CmdAlloc, CmdDispose: state_d = SLookup;
            CmdFlush: state_d = SFlush;
            default:  state_d = SEmit;
          endcase
        end
      end

      // One compare per cycle; also notes any free or unpinned frame
      SLookup: begin
        if (same_page && !match_q) begin
          match_d     = 1'b1;
          match_idx_d = idx_q;
        end
        if (!e.valid || (e.pin == '0)) begin
          avail_d = 1'b1;
        end
        idx_d = idx_q + 1'b1;
        if (idx_q == LastFrame) begin
          state_d = SApply;
        end
      end

      // Act on the lookup outcome
      SApply: begin
        rd_idx_o     = match_idx_q;
        wr_o.idx     = match_idx_q;
        wr_o.entry   = e;
        state_d      = SEmit;
        case (cmd_q)
          CmdRead, CmdAlloc: begin
            if (match_q) begin
              wr_o.we            = 1'b1;
              wr_o.entry.ref_bit = 1'b1;
              if (e.pin != PinMax) begin
                wr_o.entry.pin = e.pin + 1'b1;
              end
              res_d.frame = match_idx_q;
              res_d.hit   = 1'b1;
            end else if (!avail_q) begin
              res_d.status = StExceeded;
            end else begin
              state_d = SSweep;
            end
          end
          CmdUnpin: begin
            if (!match_q) begin
              res_d.status = StNotFound;
            end else if (e.pin == '0) begin
              res_d.status = StNotPinned;
              res_d.frame  = match_idx_q;
            end else begin
              wr_o.we          = 1'b1;
              wr_o.entry.pin   = e.pin - 1'b1;
              wr_o.entry.dirty = e.dirty | mark_q;
              res_d.frame      = match_idx_q;
            end
          end
          CmdDispose: begin
            if (match_q) begin
              wr_o.we     = 1'b1;
              wr_o.entry  = '0;
              res_d.frame = match_idx_q;
            end
          end
          default: ;
        endcase
      end

      // Clock sweep: one frame per cycle under the hand
      SSweep: begin
        rd_idx_o = hand_next;
        hand_d   = hand_next;
        wr_o.idx = hand_next;
        if (!e.valid || (!e.ref_bit && (e.pin == '0))) begin
          wr_o.we            = 1'b1;
          wr_o.entry         = '0;
          wr_o.entry.valid   = 1'b1;
          wr_o.entry.file    = file_q;
          wr_o.entry.page    = page_q;
          wr_o.entry.pin     = PinW'(1);
          wr_o.entry.ref_bit = 1'b1;
          res_d.frame        = hand_next;
          res_d.need_load    = (cmd_q == CmdRead);
          if (e.valid && e.dirty) begin
            res_d.writeback = 1'b1;
            res_d.wb_file   = e.file;
            res_d.wb_page   = e.page;
          end
          state_d = SEmit;
        end else if (e.ref_bit) begin
          wr_o.we            = 1'b1;
          wr_o.entry         = e;
          wr_o.entry.ref_bit = 1'b0;
        end
      end

      // Flush: scan frames in order, clear the file's, emit write-backs for dirty ones; stop at a pinned one
      SFlush: begin
        wr_o.idx   = idx_q;
        wr_o.entry = '0;
        if (same_file && (e.pin != '0)) begin
          res_d.status = StPinned;
          res_d.frame  = idx_q;
          state_d      = SEmit;
        end else if (!same_file || !e.dirty || out_free_i) begin
          if (same_file) begin
            wr_o.we = 1'b1;
            if (e.dirty) begin
              emit_o.load          = 1'b1;
              emit_o.res.status    = StOk;
              emit_o.res.frame     = idx_q;
              emit_o.res.writeback = 1'b1;
              emit_o.res.wb_file   = e.file;
              emit_o.res.wb_page   = e.page;
            end
          end
          idx_d = idx_q + 1'b1;
          if (idx_q == LastFrame) begin
            state_d = SEmit;
          end
        end
      end

      SEmit: begin
        if (out_free_i) begin
          emit_o.load = 1'b1;
          emit_o.res  = res_q;
          state_d     = SIdle;
        end
      end

      default: state_d = SIdle;
    endcase
    if (!is_fetch && (state_q == SSweep)) begin
      state_d = SIdle;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      hand_q  <= LastFrame;
    end else begin
      state_q <= state_d;
      hand_q  <= hand_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    file_q      <= file_d;
    page_q      <= page_d;
    mark_q      <= mark_d;
    idx_q       <= idx_d;
    match_q     <= match_d;
    match_idx_q <= match_idx_d;
    avail_q     <= avail_d;
    res_q       <= res_d;
  end

endmodule

`default_nettype wire

// ===== rtl/buffer_frame_manager_clock_core.sv =====
// Buffer frame manager top level: sequencer, frame table and output register.
// Depends on bfm_pkg, bfm_frame_table, bfm_ctrl and bfm_out_reg.
//
// Usage:
//  Input channel (in_valid_i / in_stall_o) takes one command per transfer:
//  read, unpin, alloc, dispose or flush of a file. Output channel
//  (out_valid_o / out_stall_i) returns one or more results; last_o marks the
//  final result of a command. Flush yields one write-back result per dirty
//  frame of the file before its final result; a pinned one ends it with
//  StPinned. A single compare/update unit visits one frame descriptor per
//  cycle, except while a flush waits on the output. Read, unpin, alloc,
//  dispose: a lookup of all NumFrames descriptors, an apply step, for a read
//  or alloc miss a clock sweep, then the hand-off to the output register.
//  Flush: a scan of all NumFrames descriptors, then the hand-off; unknown
//  codes: the hand-off alone. The next command is taken in the cycle after
//  the hand-off. in_stall_o is high from the accepted transfer until the
//  final result sits in the output register; a new command may then enter
//  while that result is still held. When the receiver stalls, the output
//  holds its result and a flush pauses at its next write-back.
//  Reset (rst_ni low) clears all descriptors, sets the clock hand to the
//  last frame and empties the output register.
`timescale 1ns / 1ps
`default_nettype none

module buffer_frame_manager_clock_core
  import bfm_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [2:0]        command_i,
  input  wire logic [FileW-1:0]  file_id_i,
  input  wire logic [PageW-1:0]  page_no_i,
  input  wire logic              mark_dirty_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [2:0]             status_o,
  output logic [FrameW-1:0]      frame_o,
  output logic                   hit_o,
  output logic                   need_load_o,
  output logic                   writeback_o,
  output logic [FileW-1:0]       wb_file_o,
  output logic [PageW-1:0]       wb_page_o,
  output logic                   last_o
);

  logic [FrameW-1:0] rd_idx;
  entry_t            rd_entry;
  tbl_wr_t           tbl_wr;
  emit_t             emit;
  logic              out_free;
  result_t           out_res;

  bfm_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .command_i    (command_i),
    .file_id_i    (file_id_i),
    .page_no_i    (page_no_i),
    .mark_dirty_i (mark_dirty_i),
    .rd_idx_o     (rd_idx),
    .rd_entry_i   (rd_entry),
    .wr_o         (tbl_wr),
    .out_free_i   (out_free),
    .emit_o       (emit)
  );

  bfm_frame_table u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_idx_i   (rd_idx),
    .rd_entry_o (rd_entry),
    .wr_i       (tbl_wr)
  );

  bfm_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .emit_i      (emit),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res)
  );

  assign status_o    = out_res.status;
  assign frame_o     = out_res.frame;
  assign hit_o       = out_res.hit;
  assign need_load_o = out_res.need_load;
  assign writeback_o = out_res.writeback;
  assign wb_file_o   = out_res.wb_file;
  assign wb_page_o   = out_res.wb_page;
  assign last_o      = out_res.last;

endmodule

`default_nettype wire

// ===== rtl/bfm_checker.sv =====
// Port-level checker for the buffer frame manager, with its bind.
// Depends on bfm_pkg and buffer_frame_manager_clock_core.
`timescale 1ns / 1ps
`default_nettype none

module bfm_checker
  import bfm_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_stall_o,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire logic [2:0]        status_o,
  input wire logic              hit_o,
  input wire logic              need_load_o,
  input wire logic              writeback_o,
  input wire logic              last_o
);

  // A stalled result stays presented
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // Busy right after a transfer
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("command accepted while previous one in progress");

  // Only flush write-backs come before the final result
  a_non_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> writeback_o && (status_o == StOk))
    else $error("non-final result is not a write-back");

  // A hit neither loads nor evicts
  a_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hit_o |-> !need_load_o && !writeback_o && (status_o == StOk))
    else $error("hit result with load or write-back");

endmodule

bind buffer_frame_manager_clock_core bfm_checker u_bfm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .status_o    (status_o),
  .hit_o       (hit_o),
  .need_load_o (need_load_o),
  .writeback_o (writeback_o),
  .last_o      (last_o)
);

`default_nettype wire
